@@ hdl/pwb_pkg.sv @@
// ============================================================================
// pwb_pkg - shared types and constants for the particle wall bounce step
// Field widths, configuration register codes, wall mode flags and the
// velocity bounce helper used by both axis units.
// ============================================================================
package pwb_pkg;

    // Field widths
    localparam int POS_W   = 20;   // unsigned Q12.8
    localparam int VEL_W   = 16;   // signed Q8.8
    localparam int RAD_W   = 16;   // unsigned Q8.8
    localparam int SPD_W   = 15;   // unsigned Q7.8 top speed
    localparam int WIN_W   = 12;   // whole pixels
    localparam int M10_W   = 12;   // floor(max_speed / 10)
    localparam int M15_W   = 16;   // floor(3 * max_speed / 2)
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Working widths
    localparam int VW_W  = 18;     // heated velocity, before saturation
    localparam int TST_W = 23;     // wall crossing test sums
    localparam int CLP_W = 22;     // advanced position and clamp bounds

    // Configuration register codes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_W     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_H     = 2'd2;

    // Reset values
    localparam logic [SPD_W-1:0] MAX_SPEED_RST = 15'd1280;
    localparam logic [WIN_W-1:0] WIN_W_RST     = 12'd800;
    localparam logic [WIN_W-1:0] WIN_H_RST     = 12'd600;
    localparam logic [M10_W-1:0] M10_RST       = 12'd128;
    localparam logic [M15_W-1:0] M15_RST       = 16'd1920;

    // Reciprocal of ten: (m * 52429) >> 19 is exact for all 16-bit m
    localparam logic [15:0] RECIP10       = 16'd52429;
    localparam int          RECIP10_SHIFT = 19;

    // Which heating rule is live on each wall of one axis
    typedef struct packed {
        logic lo_cold;
        logic lo_hot;
        logic hi_cold;
        logic hi_hot;
    } t_wall_mode;

    // Optional pull toward a target by averaging, then reflect and saturate
    function automatic logic signed [VEL_W-1:0] bounce(
        input logic signed [VEL_W-1:0] v,
        input logic signed [VW_W-1:0]  off,
        input logic                    apply
    );
        logic signed [VW_W-1:0] t;
        logic signed [VW_W-1:0] n;
        t = VW_W'(v);
        if (apply) begin
            t = (t + off) >>> 1;
        end
        n = -t;
        if (n > VW_W'(32767)) begin
            bounce = 16'sh7FFF;
        end else if (n < -VW_W'(32768)) begin
            bounce = 16'sh8000;
        end else begin
            bounce = n[VEL_W-1:0];
        end
    endfunction

endpackage

@@ hdl/pwb_axis.sv @@
// ============================================================================
// pwb_axis - wall tests, bounce and clamped advance for one axis
// Low wall then high wall, the high test seeing the velocity left by the
// low one, then position advance clamped to [r, arena - r].
// ============================================================================
module pwb_axis
    import pwb_pkg::*;
(
    input  logic [POS_W-1:0]        i_pos,
    input  logic signed [VEL_W-1:0] i_vel,
    input  logic [RAD_W-1:0]        i_radius,
    input  logic [POS_W-1:0]        i_arena,
    input  logic [SPD_W-1:0]        i_max_speed,
    input  logic [M10_W-1:0]        i_m10,
    input  logic [M15_W-1:0]        i_hi_hot_target,
    input  t_wall_mode              i_mode,
    output logic [POS_W-1:0]        o_pos,
    output logic signed [VEL_W-1:0] o_vel
);

    logic signed [TST_W-1:0] s_lo;
    logic signed [TST_W-1:0] s_hi;
    logic signed [VW_W-1:0]  lo_off;
    logic signed [VW_W-1:0]  hi_off;
    logic signed [VEL_W-1:0] v_mid;
    logic signed [CLP_W-1:0] p_adv;
    logic signed [CLP_W-1:0] p_hi;
    logic signed [CLP_W-1:0] p_clp;

    // Heating offsets: cold wins over hot
    always_comb begin
        lo_off = i_mode.lo_cold ? -$signed({6'b0, i_m10})
                                : -$signed({3'b0, i_max_speed});
        hi_off = i_mode.hi_cold ? $signed({6'b0, i_m10})
                                : $signed({2'b0, i_hi_hot_target});
    end

    // Low wall
    always_comb begin
        s_lo = $signed({3'b0, i_pos}) - $signed({7'b0, i_radius})
             + $signed({{(TST_W-VEL_W){i_vel[VEL_W-1]}}, i_vel});
        if (s_lo < 0) begin
            v_mid = bounce(i_vel, lo_off, i_mode.lo_cold | i_mode.lo_hot);
        end else begin
            v_mid = i_vel;
        end
    end

    // High wall, on the velocity left by the low wall
    always_comb begin
        s_hi = $signed({3'b0, i_pos}) + $signed({7'b0, i_radius})
             + $signed({{(TST_W-VEL_W){v_mid[VEL_W-1]}}, v_mid});
        if (s_hi > $signed({3'b0, i_arena})) begin
            o_vel = bounce(v_mid, hi_off, i_mode.hi_cold | i_mode.hi_hot);
        end else begin
            o_vel = v_mid;
        end
    end

    // Advance and clamp; the upper bound wins over the radius
    always_comb begin
        p_adv = $signed({2'b0, i_pos})
              + $signed({{(CLP_W-VEL_W){o_vel[VEL_W-1]}}, o_vel});
        p_hi  = $signed({2'b0, i_arena}) - $signed({6'b0, i_radius});
        p_clp = p_adv;
        if (p_clp < $signed({6'b0, i_radius})) begin
            p_clp = $signed({6'b0, i_radius});
        end
        if (p_clp > p_hi) begin
            p_clp = p_hi;
        end
        if (p_clp < 0) begin
            p_clp = '0;
        end
        o_pos = p_clp[POS_W-1:0];
    end

endmodule

@@ hdl/particle_wall_bounce_step_top.sv @@
// ============================================================================
// particle_wall_bounce_step_top - one bounce and advance step per particle
// Input register, two axis units, result register; configuration port for
// top speed and arena size.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    pos, vel, radius, keys
//   out      source     o_out_valid / i_out_stall  new pos, new vel
//   cfg      sink       i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output does not stall; the input register
// feeds the result register through the wall test, bounce and clamp chain per axis.
// Speed derivatives (top speed / 10 and 1.5x) are registered at the
// configuration write, so they cost nothing per item.
// Reset empties both stages and loads the reset register values.
// A stall on the output holds the result; the input stalls only when the
// input register is full and cannot move on.
// ============================================================================
module particle_wall_bounce_step_top
    import pwb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [POS_W-1:0]        i_pos_x,
    input  logic [POS_W-1:0]        i_pos_y,
    input  logic signed [VEL_W-1:0] i_vel_x,
    input  logic signed [VEL_W-1:0] i_vel_y,
    input  logic [RAD_W-1:0]        i_radius,
    input  logic                    i_cold_key,
    input  logic                    i_hot_key,
    input  logic                    i_shift_key,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [POS_W-1:0]        o_new_x,
    output logic [POS_W-1:0]        o_new_y,
    output logic signed [VEL_W-1:0] o_new_vx,
    output logic signed [VEL_W-1:0] o_new_vy
);

    // Configuration registers
    logic [SPD_W-1:0] r_max_speed;
    logic [WIN_W-1:0] r_win_w;
    logic [WIN_W-1:0] r_win_h;
    logic [M10_W-1:0] r_m10;
    logic [M15_W-1:0] r_m15;
    logic [SPD_W+16-1:0] cfg_prod;

    // Input stage
    logic                    r_in_vld;
    logic [POS_W-1:0]        r_px;
    logic [POS_W-1:0]        r_py;
    logic signed [VEL_W-1:0] r_vx;
    logic signed [VEL_W-1:0] r_vy;
    logic [RAD_W-1:0]        r_rad;
    logic                    r_cold;
    logic                    r_hot;
    logic                    r_shift;

    // Result stage
    logic                    r_out_vld;
    logic [POS_W-1:0]        r_nx;
    logic [POS_W-1:0]        r_ny;
    logic signed [VEL_W-1:0] r_nvx;
    logic signed [VEL_W-1:0] r_nvy;

    logic                    out_free;
    logic                    in_take;
    t_wall_mode              mode_x;
    t_wall_mode              mode_y;
    logic [POS_W-1:0]        n_nx;
    logic [POS_W-1:0]        n_ny;
    logic signed [VEL_W-1:0] n_nvx;
    logic signed [VEL_W-1:0] n_nvy;

    // Configuration writes; top speed / 10 by reciprocal multiply
    assign cfg_prod = i_cfg_data * RECIP10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MAX_SPEED_RST;
            r_win_w     <= WIN_W_RST;
            r_win_h     <= WIN_H_RST;
            r_m10       <= M10_RST;
            r_m15       <= M15_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_SPEED: begin
                    r_max_speed <= i_cfg_data;
                    r_m10       <= cfg_prod[RECIP10_SHIFT +: M10_W];
                    r_m15       <= {1'b0, i_cfg_data} + {2'b0, i_cfg_data[SPD_W-1:1]};
                end
                CFG_WIN_W: r_win_w <= i_cfg_data[WIN_W-1:0];
                CFG_WIN_H: r_win_h <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage flow control
    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_vx    <= i_vel_x;
            r_vy    <= i_vel_y;
            r_rad   <= i_radius;
            r_cold  <= i_cold_key;
            r_hot   <= i_hot_key;
            r_shift <= i_shift_key;
        end
    end

    // Wall rules: shift frees the left wall's cold and the right wall's hot
    // modes, and switches off all heating at top and bottom
    always_comb begin
        mode_x.lo_cold = r_cold;
        mode_x.lo_hot  = r_hot && !r_shift;
        mode_x.hi_cold = r_cold && !r_shift;
        mode_x.hi_hot  = r_hot;
        mode_y.lo_cold = r_cold && !r_shift;
        mode_y.lo_hot  = r_hot && !r_shift;
        mode_y.hi_cold = r_cold && !r_shift;
        mode_y.hi_hot  = r_hot && !r_shift;
    end

    pwb_axis u_axis_x (
        .i_pos           (r_px),
        .i_vel           (r_vx),
        .i_radius        (r_rad),
        .i_arena         ({r_win_w, 8'b0}),
        .i_max_speed     (r_max_speed),
        .i_m10           (r_m10),
        .i_hi_hot_target ({1'b0, r_max_speed}),
        .i_mode          (mode_x),
        .o_pos           (n_nx),
        .o_vel           (n_nvx)
    );

    // Bottom wall heats toward 1.5x top speed
    pwb_axis u_axis_y (
        .i_pos           (r_py),
        .i_vel           (r_vy),
        .i_radius        (r_rad),
        .i_arena         ({r_win_h, 8'b0}),
        .i_max_speed     (r_max_speed),
        .i_m10           (r_m10),
        .i_hi_hot_target (r_m15),
        .i_mode          (mode_y),
        .o_pos           (n_ny),
        .o_vel           (n_nvy)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_vld) begin
            r_nx  <= n_nx;
            r_ny  <= n_ny;
            r_nvx <= n_nvx;
            r_nvy <= n_nvy;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_new_x     = r_nx;
    assign o_new_y     = r_ny;
    assign o_new_vx    = r_nvx;
    assign o_new_vy    = r_nvy;

`ifndef SYNTH
    // Input stalls only while an item sits in the input register
    a_stall_needs_item : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld
    ) else $error("input stall with empty input stage");

    // An item in the input register that moves on reaches the result register
    a_item_moves : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && out_free) |=> r_out_vld
    ) else $error("item lost between stages");

    // Reset leaves both stages empty
    a_reset_empty : assert property (
        @(posedge i_clk)
        !i_rst_n |=> (!r_in_vld && !r_out_vld)
    ) else $error("stage not emptied by reset");

    // Derived speeds stay consistent with the top speed
    a_speed_derived : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_m15 == ({1'b0, r_max_speed} + {2'b0, r_max_speed[SPD_W-1:1]}))
    ) else $error("derived speed out of step with top speed");
`endif

endmodule

@@ dv/tb.sv @@
// ============================================================================
// tb - self-checking bench for particle_wall_bounce_step_top
// Particle records are queued by the stimulus process and offered by a
// clocked driver; a clocked monitor predicts the bounced and advanced
// record at every input transfer and checks each output transfer against
// the oldest prediction. Arena size and top speed are changed between
// phases while the block is empty; both sides idle at random.
// ============================================================================
module tb;
    import pwb_pkg::*;

    // Unmapped register index, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int N_PHASES  = 8;
    localparam int PHASE_LEN = 82;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [VEL_W-1:0] vel_x;
        logic [VEL_W-1:0] vel_y;
        logic [RAD_W-1:0] radius;
        logic             cold_key;
        logic             hot_key;
        logic             shift_key;
    } particle_t;

    typedef struct packed {
        logic [POS_W-1:0] new_x;
        logic [POS_W-1:0] new_y;
        logic [VEL_W-1:0] new_vx;
        logic [VEL_W-1:0] new_vy;
    } motion_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [POS_W-1:0]        i_pos_x = '0;
    logic [POS_W-1:0]        i_pos_y = '0;
    logic signed [VEL_W-1:0] i_vel_x = '0;
    logic signed [VEL_W-1:0] i_vel_y = '0;
    logic [RAD_W-1:0]        i_radius = '0;
    logic                    i_cold_key = 1'b0;
    logic                    i_hot_key = 1'b0;
    logic                    i_shift_key = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [POS_W-1:0]        o_new_x;
    logic [POS_W-1:0]        o_new_y;
    logic signed [VEL_W-1:0] o_new_vx;
    logic signed [VEL_W-1:0] o_new_vy;

    // Bench copy of the configuration registers
    logic [SPD_W-1:0] cur_max_speed = MAX_SPEED_RST;
    logic [WIN_W-1:0] cur_win_w = WIN_W_RST;
    logic [WIN_W-1:0] cur_win_h = WIN_H_RST;

    particle_t particle_q[$];
    motion_t   motion_q[$];
    particle_t next_particle;
    motion_t   seen_motion;
    motion_t   want_motion;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;
    logic rx_hold = 1'b0;
    int   tx_wait = 0;
    int   rx_wait = 0;
    int   err_count = 0;

    particle_wall_bounce_step_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_radius    (i_radius),
        .i_cold_key  (i_cold_key),
        .i_hot_key   (i_hot_key),
        .i_shift_key (i_shift_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_new_x     (o_new_x),
        .o_new_y     (o_new_y),
        .o_new_vx    (o_new_vx),
        .o_new_vy    (o_new_vy)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic longint sat_vel(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Raise to r, then lower to arena - r; the upper bound wins
    function automatic logic [POS_W-1:0] clamp_axis(longint p, longint r, longint arena);
        longint hi;
        hi = arena - r;
        if (p < r) p = r;
        if (p > hi) p = hi;
        if (p < 0) p = 0;
        if (p > 1048575) p = 1048575;
        return p[POS_W-1:0];
    endfunction

    // Walls in order left, right, top, bottom; each sees the earlier changes.
    // Averaging is a floor halving, done here by an arithmetic shift.
    function automatic motion_t predict_motion(particle_t p);
        longint  x, y, vx, vy, r, m, m10, m15, w, h;
        motion_t res;
        x   = p.pos_x;
        y   = p.pos_y;
        vx  = longint'($signed(p.vel_x));
        vy  = longint'($signed(p.vel_y));
        r   = p.radius;
        m   = cur_max_speed;
        m10 = m / 10;
        m15 = (3 * m) / 2;
        w   = longint'(cur_win_w) * 256;
        h   = longint'(cur_win_h) * 256;
        if (x - r + vx < 0) begin
            if (p.cold_key) vx = (vx - m10) >>> 1;
            else if (!p.shift_key && p.hot_key) vx = (vx - m) >>> 1;
            vx = sat_vel(-vx);
        end
        if (x + r + vx > w) begin
            if (!p.shift_key && p.cold_key) vx = (vx + m10) >>> 1;
            else if (p.hot_key) vx = (vx + m) >>> 1;
            vx = sat_vel(-vx);
        end
        if (y - r + vy < 0) begin
            if (!p.shift_key && p.cold_key) vy = (vy - m10) >>> 1;
            else if (!p.shift_key && p.hot_key) vy = (vy - m) >>> 1;
            vy = sat_vel(-vy);
        end
        if (y + r + vy > h) begin
            if (!p.shift_key && p.cold_key) vy = (vy + m10) >>> 1;
            else if (!p.shift_key && p.hot_key) vy = (vy + m15) >>> 1;
            vy = sat_vel(-vy);
        end
        res.new_x  = clamp_axis(x + vx, r, w);
        res.new_y  = clamp_axis(y + vy, r, h);
        res.new_vx = vx[VEL_W-1:0];
        res.new_vy = vy[VEL_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_particle(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                 input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
                                 input logic [RAD_W-1:0] r, input logic c, input logic h,
                                 input logic s);
        particle_t p;
        p = '{x, y, vx, vy, r, c, h, s};
        particle_q.push_back(p);
    endtask

    // Position along one axis: in half the draws close to a wall so that crossings happen
    function automatic logic [POS_W-1:0] axis_pos(longint arena, longint r);
        longint p;
        case ($urandom_range(0, 3))
            0:       p = r + longint'($urandom_range(0, 4096)) - 2048;
            1:       p = arena - r + longint'($urandom_range(0, 4096)) - 2048;
            2:       p = $urandom_range(0, int'(arena));
            default: p = $urandom_range(0, 1048575);
        endcase
        if (p < 0) p = 0;
        if (p > 1048575) p = 1048575;
        return p[POS_W-1:0];
    endfunction

    function automatic logic [VEL_W-1:0] axis_vel();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 4096)) - 2048;
            6, 7:             v = int'($urandom_range(0, 65535));
            8:                v = $urandom_range(0, 1) ? 32767 : -32768;
            default:          v = int'($urandom_range(0, 16)) - 8;
        endcase
        return v[VEL_W-1:0];
    endfunction

    function automatic particle_t random_particle();
        particle_t p;
        longint    r;
        r = ($urandom_range(0, 7) < 6) ? $urandom_range(0, 2560) : $urandom_range(0, 65535);
        p.radius    = r[RAD_W-1:0];
        p.pos_x     = axis_pos(longint'(cur_win_w) * 256, r);
        p.pos_y     = axis_pos(longint'(cur_win_h) * 256, r);
        p.vel_x     = axis_vel();
        p.vel_y     = axis_vel();
        p.cold_key  = $urandom_range(0, 1);
        p.hot_key   = $urandom_range(0, 1);
        p.shift_key = $urandom_range(0, 1);
        return p;
    endfunction

    // Register write at the falling edge, one cycle wide
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MAX_SPEED: cur_max_speed = data;
            CFG_WIN_W:     cur_win_w = data[WIN_W-1:0];
            CFG_WIN_H:     cur_win_h = data[WIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Block empty: nothing queued or offered, every prediction matched
    task automatic wait_drained();
        while (particle_q.size() != 0 || i_in_valid || motion_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] seen);
        if (want !== seen) note_error($sformatf("%s expected %h got %h", name, want, seen));
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Input driver: one record per transfer, random gap after each
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (tx_wait > 0) begin
                tx_wait--;
                i_in_valid <= 1'b0;
            end else if (particle_q.size() != 0) begin
                next_particle = particle_q.pop_front();
                i_pos_x     <= next_particle.pos_x;
                i_pos_y     <= next_particle.pos_y;
                i_vel_x     <= next_particle.vel_x;
                i_vel_y     <= next_particle.vel_y;
                i_radius    <= next_particle.radius;
                i_cold_key  <= next_particle.cold_key;
                i_hot_key   <= next_particle.hot_key;
                i_shift_key <= next_particle.shift_key;
                i_in_valid  <= 1'b1;
                if (tx_burst || $urandom_range(0, 3) == 0) tx_wait = 0;
                else tx_wait = $urandom_range(0, 13);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output receiver: random stall before each result, plus the long hold
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (out_taken) begin
            if (rx_burst || $urandom_range(0, 3) == 0) rx_wait = 0;
            else rx_wait = $urandom_range(0, 13);
        end
        if (rx_hold || rx_wait > 0) begin
            i_out_stall <= 1'b1;
            if (!rx_hold && rx_wait > 0 && o_out_valid) rx_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict at input transfer, check at output transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_in_valid && !o_in_stall;
        out_taken <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                motion_q.push_back(predict_motion('{i_pos_x, i_pos_y, i_vel_x, i_vel_y,
                                                    i_radius, i_cold_key, i_hot_key,
                                                    i_shift_key}));
            if (o_out_valid && !i_out_stall) begin
                seen_motion = '{o_new_x, o_new_y, o_new_vx, o_new_vy};
                if (motion_q.size() == 0) begin
                    note_error($sformatf("result with nothing pending: %h", seen_motion));
                end else begin
                    want_motion = motion_q.pop_front();
                    check_field("new_x", want_motion.new_x, seen_motion.new_x);
                    check_field("new_y", want_motion.new_y, seen_motion.new_y);
                    check_field("new_vx", POS_W'(want_motion.new_vx), POS_W'(seen_motion.new_vx));
                    check_field("new_vy", POS_W'(want_motion.new_vy), POS_W'(seen_motion.new_vy));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] spd_d, w_d, h_d;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed records with the reset configuration
        push_particle(0, 0, 0, 0, 0, 0, 0, 0);
        push_particle(1000, 50000, -1000, 0, 512, 1, 0, 0);     // left, cold
        push_particle(1000, 50000, -1000, 0, 512, 0, 1, 0);     // left, hot
        push_particle(1000, 50000, -1000, 0, 512, 0, 1, 1);     // left, hot masked by shift
        push_particle(1000, 50000, -1000, 0, 512, 1, 0, 1);     // left, cold ignores shift
        push_particle(204000, 50000, 600, 0, 512, 1, 0, 0);     // right, cold
        push_particle(204000, 50000, 600, 0, 512, 1, 1, 1);     // right, shift falls to hot
        push_particle(204000, 50000, 600, 0, 512, 1, 0, 1);     // right, plain reflect
        push_particle(204000, 50000, 600, 0, 512, 0, 1, 0);     // right, hot
        push_particle(50000, 300, 0, -400, 256, 1, 0, 0);       // top, cold
        push_particle(50000, 300, 0, -400, 256, 0, 1, 0);       // top, hot
        push_particle(50000, 300, 0, -400, 256, 1, 1, 1);       // top, shift
        push_particle(50000, 153000, 0, 700, 256, 1, 0, 0);     // bottom, cold
        push_particle(50000, 153000, 0, 700, 256, 0, 1, 0);     // bottom, hot 1.5x
        push_particle(50000, 153000, 0, 700, 256, 0, 1, 1);     // bottom, shift
        push_particle(100, 50000, 16'h8000, 0, 0, 0, 0, 0);     // reflect saturates
        push_particle(50000, 100, 0, 16'h8000, 0, 0, 1, 0);
        push_particle(204000, 50000, 16'h7FFF, 0, 0, 0, 1, 0);
        push_particle(50000, 153000, 0, 16'h7FFF, 0, 0, 1, 0);
        push_particle(100, 50000, -200, 0, 16'hFFFF, 0, 1, 0);
        push_particle(20'hFFFFF, 20'hFFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1, 1, 1);
        push_particle(0, 0, -5, -5, 100, 1, 1, 0);               // corner, left and top walls
        push_particle(100000, 80000, 3, -3, 16'hFFFF, 0, 0, 0);
        wait_drained();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin spd_d = 0;     w_d = 800;      h_d = 600;      end
                1: begin spd_d = 32767; w_d = 4095;     h_d = 4095;     end
                2: begin spd_d = 1280;  w_d = 800;      h_d = 600;      end
                3: begin spd_d = $urandom_range(0, 32767); w_d = 15'h1000;
                         h_d = $urandom_range(1, 4095); end
                4: begin spd_d = 9;     w_d = 1;        h_d = 1;        end
                5: begin spd_d = $urandom_range(0, 32767); w_d = $urandom_range(0, 32767);
                         h_d = 15'h7FFF; end
                6: begin spd_d = 32767; w_d = 2;        h_d = 15'h1000; end
                default: begin spd_d = $urandom_range(0, 32767);
                         w_d = $urandom_range(0, 32767); h_d = $urandom_range(0, 32767); end
            endcase
            cfg_write(CFG_MAX_SPEED, spd_d);
            cfg_write(CFG_WIN_W, w_d);
            cfg_write(CFG_WIN_H, h_d);
            if (ph == 4) cfg_write(CFG_UNUSED, $urandom_range(0, 32767));
            tx_burst = (ph == 2 || ph == 5);
            rx_burst = (ph == 2 || ph == 5);
            for (int k = 0; k < PHASE_LEN; k++) particle_q.push_back(random_particle());
            // Receiver holds off while the sender keeps offering
            if (ph == 2) begin
                @(negedge i_clk);
                rx_hold <= 1'b1;
                repeat (120) @(negedge i_clk);
                rx_hold <= 1'b0;
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0 && motion_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
